// ----- sv/limit_order_matching_unit_defines.svh -----
// Assertion macros used by the port-level checker of the order matching unit.
// Depends on nothing; each macro expects clk and arst_n in scope.
`ifndef LIMIT_ORDER_MATCHING_UNIT_DEFINES_SVH
`define LIMIT_ORDER_MATCHING_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LOMU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define LOMU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/lomu_pkg.sv -----
// Shared types and constants of the order matching unit.
// Depends on nothing; used by every module of the unit.
`default_nettype none
package lomu_pkg;
	localparam int BOOK_DEPTH_DEF = 32;
	localparam int FIELD_W = 32;
	localparam int COUNT_PORT_W = 6;

	typedef enum logic [2:0] {
		KIND_TRADE = 3'd0,
		KIND_RESTED = 3'd1,
		KIND_FILLED = 3'd2,
		KIND_ZERO = 3'd3,
		KIND_DROPPED = 3'd4
	} kind_t;

	// One resting order as stored in a side's memory.
	typedef struct packed {
		logic [FIELD_W-1:0] price;
		logic [FIELD_W-1:0] id;
		logic [FIELD_W-1:0] qty;
		logic [FIELD_W-1:0] stamp;
	} entry_t;
endpackage
`default_nettype wire

// ----- sv/lomu_book_mem.sv -----
// One side of the book: a synchronous memory of resting orders.
// Depends on lomu_pkg for the entry type.
`default_nettype none
module lomu_book_mem import lomu_pkg::*; #(
	parameter int DEPTH = BOOK_DEPTH_DEF,
	parameter int IDXW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [IDXW-1:0] waddr,
	input wire entry_t wdata,
	input wire logic [IDXW-1:0] raddr,
	output entry_t rdata
);
	entry_t mem_q [DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

// ----- sv/limit_order_matching_unit.sv -----
// Limit order book with price-time matching, one memory per book side.
// A clear is taken while idle; a zero-quantity order goes straight to its status beat.
// A trade steps through check, match and emit; one that empties a resting order adds a rescan
// of the opposite side if entries remain, after a move of the last entry into the hole if needed.
// Resting passes check (and match after a failed cross), rest and status; one item at a time.
// arst_n clears counts, trade sequence, arrival counter and control; memories keep contents.
`default_nettype none
module limit_order_matching_unit import lomu_pkg::*; #(
	parameter int BOOK_DEPTH = BOOK_DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic operation,
	input wire logic side,
	input wire logic [31:0] order_tag,
	input wire logic [31:0] limit_price,
	input wire logic [31:0] order_quantity,
	output logic out_valid,
	input wire logic out_stall,
	output logic [2:0] kind,
	output logic [31:0] buyer_id,
	output logic [31:0] seller_id,
	output logic [31:0] trade_price,
	output logic [31:0] trade_quantity,
	output logic [31:0] trade_sequence,
	output logic last,
	output logic [31:0] best_bid_price,
	output logic [31:0] best_ask_price,
	output logic [5:0] bids_resting,
	output logic [5:0] asks_resting
);
	localparam int IDXW = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
	localparam int CNTW = $clog2(BOOK_DEPTH + 1);
	localparam logic [CNTW-1:0] FULL = CNTW'(BOOK_DEPTH);

	// The sequencer walks one order through check, match, optional move of the
	// last entry into a hole, a rescan of the opposite side, resting, and the beats out.
	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_CHECK = 8'b0000_0010,
		ST_MATCH = 8'b0000_0100,
		ST_MOVE = 8'b0000_1000,
		ST_SCAN = 8'b0001_0000,
		ST_TEMIT = 8'b0010_0000,
		ST_REST = 8'b0100_0000,
		ST_STATUS = 8'b1000_0000
	} state_t;

	state_t state_q;
	logic buy_q;
	logic [31:0] id_q, limit_q, rem_q, seq_q, arr_q;
	logic [CNTW-1:0] bid_cnt_q, ask_cnt_q;
	logic [IDXW-1:0] bid_best_idx_q, ask_best_idx_q;
	logic [31:0] bid_best_price_q, ask_best_price_q, bid_best_stamp_q, ask_best_stamp_q;
	logic [31:0] tr_other_q, tr_price_q, tr_qty_q;
	kind_t st_kind_q;
	logic [CNTW-1:0] scan_q;
	logic scan_vld_s1;
	logic [IDXW-1:0] scan_addr_s1;

	// Output register.
	logic out_valid_q, last_q;
	logic [2:0] kind_q;
	logic [31:0] buyer_q, seller_q, tprice_q, tqty_q, tseq_q, obid_q, oask_q;
	logic [5:0] obids_q, oasks_q;

	entry_t bid_rdata, ask_rdata, rd, wdata;
	logic bid_we, ask_we;
	logic [IDXW-1:0] waddr, raddr;

	logic [CNTW-1:0] opp_cnt, own_cnt, opp_cnt_dec;
	logic [IDXW-1:0] opp_best_idx, last_idx;
	logic [31:0] opp_best_price, opp_best_stamp, own_best_price;
	logic crosses, take_new, scan_better, scan_take, scan_issue, out_free;
	logic [31:0] tq, newq;

	assign opp_cnt = buy_q ? ask_cnt_q : bid_cnt_q;
	assign own_cnt = buy_q ? bid_cnt_q : ask_cnt_q;
	assign opp_cnt_dec = opp_cnt - CNTW'(1);
	assign last_idx = opp_cnt_dec[IDXW-1:0];
	assign opp_best_idx = buy_q ? ask_best_idx_q : bid_best_idx_q;
	assign opp_best_price = buy_q ? ask_best_price_q : bid_best_price_q;
	assign opp_best_stamp = buy_q ? ask_best_stamp_q : bid_best_stamp_q;
	assign own_best_price = buy_q ? bid_best_price_q : ask_best_price_q;
	assign rd = buy_q ? ask_rdata : bid_rdata;

	// A buy crosses asks at or below its limit, a sell bids at or above.
	assign crosses = buy_q ? (rd.price <= limit_q) : (rd.price >= limit_q);
	assign tq = (rem_q < rd.qty) ? rem_q : rd.qty;
	assign newq = rd.qty - tq;

	// A new resting order is the youngest, so it only wins on a strictly better price.
	assign take_new = (own_cnt == '0) ||
		(buy_q ? (limit_q > own_best_price) : (limit_q < own_best_price));

	// Rescan compare: price first, then the larger age wins.
	assign scan_better = (rd.price != opp_best_price) ?
		(buy_q ? (rd.price < opp_best_price) : (rd.price > opp_best_price)) :
		((arr_q - rd.stamp) > (arr_q - opp_best_stamp));
	assign scan_take = scan_vld_s1 && ((scan_addr_s1 == '0) || scan_better);
	assign scan_issue = (scan_q < opp_cnt);

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE);

	// Memory port control. When a read and a write of one entry share a cycle the
	// read data is never used; the sequencer orders all other accesses, so no
	// forwarding is needed.
	always_comb begin
		bid_we = 1'b0;
		ask_we = 1'b0;
		waddr = opp_best_idx;
		wdata = rd;
		raddr = '0;
		case (state_q)
			ST_CHECK: begin
				raddr = opp_best_idx;
			end
			ST_MATCH: begin
				raddr = last_idx;
				if (crosses && (newq != '0)) begin
					wdata.qty = newq;
					bid_we = !buy_q;
					ask_we = buy_q;
				end
			end
			ST_MOVE: begin
				bid_we = !buy_q;
				ask_we = buy_q;
			end
			ST_SCAN: begin
				raddr = scan_q[IDXW-1:0];
			end
			ST_REST: begin
				waddr = own_cnt[IDXW-1:0];
				wdata = '{price: limit_q, id: id_q, qty: rem_q, stamp: arr_q + 32'd1};
				if (own_cnt < FULL) begin
					bid_we = buy_q;
					ask_we = !buy_q;
				end
			end
			default: begin
			end
		endcase
	end

	lomu_book_mem #(.DEPTH(BOOK_DEPTH), .IDXW(IDXW)) u_bid_mem (
		.clk(clk), .we(bid_we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(bid_rdata)
	);

	lomu_book_mem #(.DEPTH(BOOK_DEPTH), .IDXW(IDXW)) u_ask_mem (
		.clk(clk), .we(ask_we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(ask_rdata)
	);

	// Sequencer and book bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bid_cnt_q <= '0;
			ask_cnt_q <= '0;
			seq_q <= '0;
			arr_q <= '0;
			scan_vld_s1 <= 1'b0;
		end else begin
			scan_vld_s1 <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						buy_q <= !side;
						id_q <= order_tag;
						limit_q <= limit_price;
						rem_q <= order_quantity;
						if (operation) begin
							bid_cnt_q <= '0;
							ask_cnt_q <= '0;
							seq_q <= '0;
							arr_q <= '0;
						end else if (order_quantity == '0) begin
							st_kind_q <= KIND_ZERO;
							state_q <= ST_STATUS;
						end else begin
							state_q <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					if (rem_q == '0) begin
						st_kind_q <= KIND_FILLED;
						state_q <= ST_STATUS;
					end else if (opp_cnt == '0) begin
						state_q <= ST_REST;
					end else begin
						state_q <= ST_MATCH;
					end
				end
				ST_MATCH: begin
					if (!crosses) begin
						state_q <= ST_REST;
					end else begin
						rem_q <= rem_q - tq;
						seq_q <= seq_q + 32'd1;
						tr_other_q <= rd.id;
						tr_price_q <= rd.price;
						tr_qty_q <= tq;
						scan_q <= '0;
						if (newq != '0) begin
							state_q <= ST_TEMIT;
						end else if (opp_best_idx != last_idx) begin
							state_q <= ST_MOVE;
						end else begin
							if (buy_q) ask_cnt_q <= opp_cnt_dec;
							else bid_cnt_q <= opp_cnt_dec;
							state_q <= (opp_cnt_dec == '0) ? ST_TEMIT : ST_SCAN;
						end
					end
				end
				ST_MOVE: begin
					if (buy_q) ask_cnt_q <= opp_cnt_dec;
					else bid_cnt_q <= opp_cnt_dec;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (scan_issue) begin
						scan_q <= scan_q + CNTW'(1);
						scan_addr_s1 <= scan_q[IDXW-1:0];
						scan_vld_s1 <= 1'b1;
					end else if (!scan_vld_s1) begin
						state_q <= ST_TEMIT;
					end
					if (scan_take) begin
						if (buy_q) begin
							ask_best_idx_q <= scan_addr_s1;
							ask_best_price_q <= rd.price;
							ask_best_stamp_q <= rd.stamp;
						end else begin
							bid_best_idx_q <= scan_addr_s1;
							bid_best_price_q <= rd.price;
							bid_best_stamp_q <= rd.stamp;
						end
					end
				end
				ST_TEMIT: begin
					if (out_free) state_q <= ST_CHECK;
				end
				ST_REST: begin
					if (own_cnt >= FULL) begin
						st_kind_q <= KIND_DROPPED;
					end else begin
						st_kind_q <= KIND_RESTED;
						arr_q <= arr_q + 32'd1;
						if (buy_q) begin
							bid_cnt_q <= bid_cnt_q + CNTW'(1);
							if (take_new) begin
								bid_best_idx_q <= own_cnt[IDXW-1:0];
								bid_best_price_q <= limit_q;
								bid_best_stamp_q <= arr_q + 32'd1;
							end
						end else begin
							ask_cnt_q <= ask_cnt_q + CNTW'(1);
							if (take_new) begin
								ask_best_idx_q <= own_cnt[IDXW-1:0];
								ask_best_price_q <= limit_q;
								ask_best_stamp_q <= arr_q + 32'd1;
							end
						end
					end
					state_q <= ST_STATUS;
				end
				ST_STATUS: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register: loads a trade beat or a status beat, holds while stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free && ((state_q == ST_TEMIT) || (state_q == ST_STATUS))) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && ((state_q == ST_TEMIT) || (state_q == ST_STATUS))) begin
			obid_q <= (bid_cnt_q != '0) ? bid_best_price_q : 32'd0;
			oask_q <= (ask_cnt_q != '0) ? ask_best_price_q : 32'd0;
			obids_q <= COUNT_PORT_W'(bid_cnt_q);
			oasks_q <= COUNT_PORT_W'(ask_cnt_q);
			if (state_q == ST_TEMIT) begin
				kind_q <= KIND_TRADE;
				buyer_q <= buy_q ? id_q : tr_other_q;
				seller_q <= buy_q ? tr_other_q : id_q;
				tprice_q <= tr_price_q;
				tqty_q <= tr_qty_q;
				tseq_q <= seq_q;
				last_q <= 1'b0;
			end else begin
				kind_q <= st_kind_q;
				buyer_q <= '0;
				seller_q <= '0;
				tprice_q <= '0;
				tqty_q <= '0;
				tseq_q <= '0;
				last_q <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign kind = kind_q;
	assign buyer_id = buyer_q;
	assign seller_id = seller_q;
	assign trade_price = tprice_q;
	assign trade_quantity = tqty_q;
	assign trade_sequence = tseq_q;
	assign last = last_q;
	assign best_bid_price = obid_q;
	assign best_ask_price = oask_q;
	assign bids_resting = obids_q;
	assign asks_resting = oasks_q;
endmodule
`default_nettype wire

// ----- sv/lomu_checker.sv -----
// Port-level checks of the order matching unit and their bind.
// Depends on lomu_pkg and the assertion macro header.
`default_nettype none
`include "limit_order_matching_unit_defines.svh"
module lomu_checker import lomu_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic [2:0] kind,
	input wire logic [31:0] trade_quantity,
	input wire logic [31:0] trade_sequence,
	input wire logic last
);
	`LOMU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(kind) && $stable(last), "output beat changed while stalled")
	`LOMU_ASSERT_NOW(a_trade_not_last, out_valid && !last, kind == KIND_TRADE, "non-final beat is not a trade")
	`LOMU_ASSERT_NOW(a_status_clean, out_valid && last, kind != KIND_TRADE && trade_sequence == 32'd0, "status beat carries trade data")
	`LOMU_ASSERT_NOW(a_trade_qty, out_valid && !last, trade_quantity != 32'd0 && trade_sequence != 32'd0, "trade beat with zero quantity or sequence")
endmodule

bind limit_order_matching_unit lomu_checker u_lomu_checker (.*);
`default_nettype wire

// ----- dv/lomu_checker.sv -----
// Checker for the order matching unit: watches both channels, predicts results.
// Depends on lomu_pkg for the result kinds and the book depth.
`timescale 1ns / 100ps
module lomu_scoreboard import lomu_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic operation,
	input wire logic side,
	input wire logic [31:0] order_tag,
	input wire logic [31:0] limit_price,
	input wire logic [31:0] order_quantity,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic [2:0] kind,
	input wire logic [31:0] buyer_id,
	input wire logic [31:0] seller_id,
	input wire logic [31:0] trade_price,
	input wire logic [31:0] trade_quantity,
	input wire logic [31:0] trade_sequence,
	input wire logic last,
	input wire logic [31:0] best_bid_price,
	input wire logic [31:0] best_ask_price,
	input wire logic [5:0] bids_resting,
	input wire logic [5:0] asks_resting,
	output int fail_count,
	output int pending_count,
	output int trade_count
);
	typedef struct {
		logic [2:0] kind;
		logic [31:0] buyer, seller, price, qty, seq;
		logic last;
		logic [31:0] bid_top, ask_top;
		logic [5:0] nbid, nask;
	} beat_t;

	// Book model: side 0 holds bids, side 1 holds asks.
	entry_t book [2][BOOK_DEPTH_DEF];
	int unsigned depth_of [2];
	logic [31:0] seq_num, arrivals;
	beat_t result_queue [$];

	function automatic int top_slot(int s);
		int b;
		logic better;
		b = 0;
		for (int i = 1; i < depth_of[s]; i++) begin
			if (book[s][i].price != book[s][b].price)
				better = (s == 0) ? (book[s][i].price > book[s][b].price)
					: (book[s][i].price < book[s][b].price);
			else
				better = (arrivals - book[s][i].stamp) > (arrivals - book[s][b].stamp);
			if (better)
				b = i;
		end
		return b;
	endfunction

	task automatic push_beat(kind_t k, logic [31:0] by, logic [31:0] sl,
			logic [31:0] p, logic [31:0] q, logic [31:0] sq, logic lst);
		beat_t r;
		r.kind = k; r.buyer = by; r.seller = sl; r.price = p; r.qty = q;
		r.seq = sq; r.last = lst;
		r.bid_top = depth_of[0] ? book[0][top_slot(0)].price : 32'd0;
		r.ask_top = depth_of[1] ? book[1][top_slot(1)].price : 32'd0;
		r.nbid = 6'(depth_of[0]); r.nask = 6'(depth_of[1]);
		result_queue.push_back(r);
	endtask

	task automatic match_order(logic op, logic sd, logic [31:0] id,
			logic [31:0] lim, logic [31:0] q);
		int o, i, l;
		logic [31:0] rem, tq, p, other;
		o = sd ? 0 : 1;
		rem = q;
		if (op) begin
			depth_of[0] = 0; depth_of[1] = 0; seq_num = 0; arrivals = 0;
			return;
		end
		if (rem == 0) begin
			push_beat(KIND_ZERO, 0, 0, 0, 0, 0, 1'b1);
			return;
		end
		while (rem != 0 && depth_of[o] > 0) begin
			i = top_slot(o);
			p = book[o][i].price;
			other = book[o][i].id;
			if (sd == 1'b0 ? (p > lim) : (p < lim))
				break;
			tq = (rem < book[o][i].qty) ? rem : book[o][i].qty;
			rem -= tq;
			book[o][i].qty -= tq;
			if (book[o][i].qty == 0) begin
				l = depth_of[o] - 1;
				book[o][i] = book[o][l];
				depth_of[o]--;
			end
			seq_num++;
			push_beat(KIND_TRADE, sd ? other : id, sd ? id : other, p, tq, seq_num, 1'b0);
		end
		if (rem == 0)
			push_beat(KIND_FILLED, 0, 0, 0, 0, 0, 1'b1);
		else if (depth_of[sd] >= BOOK_DEPTH_DEF)
			push_beat(KIND_DROPPED, 0, 0, 0, 0, 0, 1'b1);
		else begin
			arrivals++;
			book[sd][depth_of[sd]] = '{price: lim, id: id, qty: rem, stamp: arrivals};
			depth_of[sd]++;
			push_beat(KIND_RESTED, 0, 0, 0, 0, 0, 1'b1);
		end
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s expected %0d actual %0d", name, want, got);
			fail_count++;
		end
	endtask

	initial begin
		fail_count = 0; trade_count = 0; pending_count = 0;
		depth_of[0] = 0; depth_of[1] = 0; seq_num = 0; arrivals = 0;
	end

	always @(posedge clk) begin
		beat_t w;
		if (arst_n) begin
			if (in_valid && !in_stall)
				match_order(operation, side, order_tag, limit_price, order_quantity);
			if (out_valid && !out_stall) begin
				if (result_queue.size() == 0) begin
					$error("result beat with no expectation, kind %0d", kind);
					fail_count++;
				end else begin
					w = result_queue.pop_front();
					if (w.kind == KIND_TRADE)
						trade_count++;
					check_field("kind", 32'(w.kind), 32'(kind));
					check_field("buyer_id", w.buyer, buyer_id);
					check_field("seller_id", w.seller, seller_id);
					check_field("trade_price", w.price, trade_price);
					check_field("trade_quantity", w.qty, trade_quantity);
					check_field("trade_sequence", w.seq, trade_sequence);
					check_field("last", 32'(w.last), 32'(last));
					check_field("best_bid_price", w.bid_top, best_bid_price);
					check_field("best_ask_price", w.ask_top, best_ask_price);
					check_field("bids_resting", 32'(w.nbid), 32'(bids_resting));
					check_field("asks_resting", 32'(w.nask), 32'(asks_resting));
				end
			end
		end
		pending_count = result_queue.size();
	end
endmodule

// ----- dv/tb_top.sv -----
// Top of the order matching unit testbench: clock, reset, stimulus and verdict.
// Depends on lomu_pkg, the unit itself and the lomu_scoreboard module.
`timescale 1ns / 100ps
module tb_top;
	logic clk, arst_n;
	logic in_valid, in_stall, operation, side;
	logic [31:0] order_tag, limit_price, order_quantity;
	logic out_valid, out_stall, last;
	logic [2:0] kind;
	logic [31:0] buyer_id, seller_id, trade_price, trade_quantity, trade_sequence;
	logic [31:0] best_bid_price, best_ask_price;
	logic [5:0] bids_resting, asks_resting;
	int fail_count, pending_count, trade_count;
	int cycle_count;
	int unsigned send_idle_pct, recv_idle_pct;
	int items_sent;

	localparam int CYCLE_LIMIT = 5000000;

	always begin
		clk = 1'b0; #1;
		clk = 1'b1; #1;
	end

	limit_order_matching_unit DUT (.*);

	lomu_scoreboard u_checker (.*);

	// The receiver stalls at random; the percentage is set per phase.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else
			out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// A run-away guard: a stuck handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Sends one beat and holds it until the unit takes it. Valid stays high
	// between beats unless an idle gap is drawn, so it is written once per step.
	task automatic send_beat(logic op, logic sd, logic [31:0] id,
			logic [31:0] lim, logic [31:0] q);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op; side <= sd; order_tag <= id;
		limit_price <= lim; order_quantity <= q;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
	endtask

	// Most orders sit near a narrow price band so they cross and rest often.
	task automatic random_order();
		logic [31:0] p, q;
		int r;
		r = $urandom_range(99);
		p = 32'd1000 + $urandom_range(12);
		q = $urandom_range(1, 40);
		if (r < 3)
			send_beat(1'b1, 1'($urandom), $urandom, $urandom, $urandom);
		else if (r < 6)
			send_beat(1'b0, 1'($urandom), $urandom, $urandom, 32'd0);
		else if (r < 12)
			send_beat(1'b0, 1'($urandom), $urandom, $urandom, $urandom);
		else
			send_beat(1'b0, 1'($urandom), $urandom, p, q);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0; operation = 1'b0; side = 1'b0;
		order_tag = '0; limit_price = '0; order_quantity = '0;
		cycle_count = 0; items_sent = 0;
		send_idle_pct = 0; recv_idle_pct = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: zero quantity, extremes of price and quantity,
		// equal-price time priority, a sweep over several levels, a partial
		// fill that keeps its place, and a clear.
		send_beat(1'b0, 1'b0, 32'd1, 32'd100, 32'd0);
		send_beat(1'b0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_beat(1'b0, 1'b0, 32'd2, 32'd0, 32'd5);
		send_beat(1'b0, 1'b0, 32'd3, 32'hFFFF_FFFF, 32'd7);
		send_beat(1'b0, 1'b1, 32'd4, 32'd0, 32'd1);
		send_beat(1'b1, 1'b0, 32'd0, 32'd0, 32'd0);
		send_beat(1'b0, 1'b1, 32'd10, 32'd50, 32'd3);
		send_beat(1'b0, 1'b1, 32'd11, 32'd50, 32'd4);
		send_beat(1'b0, 1'b1, 32'd12, 32'd49, 32'd2);
		send_beat(1'b0, 1'b1, 32'd13, 32'd52, 32'd9);
		send_beat(1'b0, 1'b0, 32'd14, 32'd48, 32'd6);
		send_beat(1'b0, 1'b0, 32'd15, 32'd51, 32'd7);
		send_beat(1'b0, 1'b0, 32'd16, 32'd60, 32'd20);
		send_beat(1'b0, 1'b1, 32'd17, 32'd40, 32'd3);
		send_beat(1'b1, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// Fill one side to the brim, then one more to be dropped, then a
		// sell that sweeps all of them in one item.
		for (int i = 0; i < 33; i++)
			send_beat(1'b0, 1'b0, 32'd100 + i, 32'd200 + (i % 4), 32'd2);
		send_beat(1'b0, 1'b1, 32'd999, 32'd0, 32'd100);
		send_beat(1'b1, 1'b0, 32'd0, 32'd0, 32'd0);

		// Random part in three idling phases.
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 26 : (ph == 1) ? 71 : 0;
			recv_idle_pct = (ph == 0) ? 71 : (ph == 1) ? 26 : 0;
			for (int n = 0; n < 117; n++)
				random_order();
		end
		in_valid <= 1'b0;

		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);

		$display("Sent %0d input beats across three idling phases; %0d trades checked.",
			items_sent, trade_count);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
